// ===== hdl/srt_pkg.sv =====
// shared widths, codes and the entry record type of the sorted record table
package srt_pkg;

    // field widths
    localparam int ID_W     = 27;
    localparam int NAME_W   = 16;
    localparam int KEY_W    = 20;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    // defaults handed to the top level
    localparam int                 DEF_TABLE_DEPTH     = 16;
    localparam logic [KEY_W-1:0]   DEF_PURGE_THRESHOLD = 20'd2000;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PURGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMIT       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PURGE_DONE = 2'd3;

    // one stored record
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NAME_W-1:0] name;
        logic [KEY_W-1:0]  key;
    } t_entry;

endpackage

// ===== hdl/srt_entry_ram.sv =====
// entry store: one write port, one registered read port
module srt_entry_ram #(
    parameter int DEPTH = srt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  srt_pkg::t_entry          i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output srt_pkg::t_entry          o_rdata
);
    import srt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sorted_record_table_unit.sv =====
// sorted record table: top level with sequencer, shared key comparator and entry store
//
// Usage: raise start with i_kind and the record fields; the command transfers at an edge
// where start is high and busy is low, and busy stays high until the last result is out.
// Each result sits on the o_ ports for one cycle marked by o_strobe; o_last marks the
// final result of a command. The receiver cannot stall, so results never wait.
// The purge threshold transfers on i_cfg_valid (o_cfg_ready is always high); write it
// only while busy is low and no result is pending.
// Steps (n = entries held; each entry is read, then compared, through the single read
// port of the entry store and the one shared comparator):
//   insert: each entry above the new key, from the top down, is moved up one place;
//           the record goes behind the first entry not above it (first if none is),
//           straight in on an empty table; refused with ST_FULL on a full table
//   purge:  each of the n entries is compared with the threshold; one result
//   dump:   one result per entry, lowest key first; an empty table gives one result
//   kind 3 is ignored and gives no result.
// Reset (synchronous, active low) empties the table and restores the threshold to 2000;
// the store itself is not cleared, no clearing pass is needed.
module sorted_record_table_unit #(
    parameter int TABLE_DEPTH = srt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [srt_pkg::KIND_W-1:0]    i_kind,
    input  logic [srt_pkg::ID_W-1:0]      i_record_id,
    input  logic [srt_pkg::NAME_W-1:0]    i_name_handle,
    input  logic [srt_pkg::KEY_W-1:0]     i_key_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srt_pkg::KEY_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic [srt_pkg::STATUS_W-1:0]  o_status,
    output logic [srt_pkg::ID_W-1:0]      o_out_id,
    output logic [srt_pkg::NAME_W-1:0]    o_out_name,
    output logic [srt_pkg::KEY_W-1:0]     o_out_key,
    output logic [srt_pkg::CNT_W-1:0]     o_entry_count,
    output logic [srt_pkg::CNT_W-1:0]     o_removed_count,
    output logic                          o_last
);
    import srt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_PRG_RD,
        S_PRG_CMP,
        S_DMP_RD,
        S_DMP_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_wr, n_wr;
    logic [CW-1:0]         r_fill, n_fill;
    logic [KEY_W-1:0]      r_thr, n_thr;
    t_entry                r_new, n_new;
    logic                  n_strobe;
    logic [STATUS_W-1:0]   n_status;
    t_entry                n_out;
    logic [CW-1:0]         n_removed;
    logic                  n_last;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    t_entry                mem_wdata;
    logic [AW-1:0]         mem_raddr;
    t_entry                mem_rdata;

    logic [KEY_W-1:0]      cmp_b;
    logic                  key_le;
    logic [CW-1:0]         fill_m1;
    logic [CW-1:0]         idx_ext;
    logic [CW-1:0]         wr_next;
    logic [CW+CNT_W-1:0]   fill_wide;
    logic [CW+CNT_W-1:0]   removed_wide;

    srt_entry_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // shared key comparator: against the new key on insert, the threshold on purge
    assign cmp_b  = (r_state == S_PRG_CMP) ? r_thr : r_new.key;
    assign key_le = (mem_rdata.key <= cmp_b);

    assign fill_m1 = r_fill - 1'b1;
    assign idx_ext = CW'(r_idx);
    assign wr_next = r_wr + CW'(key_le);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // count fields fitted to the result width
    assign fill_wide    = {{CNT_W{1'b0}}, n_fill};
    assign removed_wide = {{CNT_W{1'b0}}, n_removed};

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_fill    = r_fill;
        n_new     = r_new;
        n_thr     = r_thr;
        n_strobe  = 1'b0;
        n_status  = ST_INS_DONE;
        n_out     = '0;
        n_removed = '0;
        n_last    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx + 1'b1;
        mem_wdata = r_new;
        mem_raddr = r_idx;

        if (i_cfg_valid) begin
            n_thr = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_INSERT: begin
                            if (r_fill == CW'(TABLE_DEPTH)) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                                n_last   = 1'b1;
                            end else begin
                                n_new = '{id: i_record_id, name: i_name_handle,
                                          key: i_key_value};
                                if (r_fill == '0) begin
                                    n_idx   = '0;
                                    n_state = S_INS_PUT;
                                end else begin
                                    n_idx   = fill_m1[AW-1:0];
                                    n_state = S_INS_RD;
                                end
                            end
                        end
                        KIND_PURGE: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_PURGE_DONE;
                                n_last   = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_wr    = '0;
                                n_state = S_PRG_RD;
                            end
                        end
                        KIND_DUMP: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_PURGE_DONE;
                                n_last   = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                // shift the larger entry up one place, or drop the new one in behind it
                mem_we = 1'b1;
                if (!key_le) begin
                    mem_wdata = mem_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_INS_RD;
                    end
                end else begin
                    mem_wdata = r_new;
                    n_fill    = r_fill + 1'b1;
                    n_strobe  = 1'b1;
                    n_status  = ST_INS_DONE;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_new;
                n_fill    = r_fill + 1'b1;
                n_strobe  = 1'b1;
                n_status  = ST_INS_DONE;
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end
            S_PRG_RD: begin
                n_state = S_PRG_CMP;
            end
            S_PRG_CMP: begin
                // keep entries at or below the threshold, packed downwards
                if (key_le) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (idx_ext == fill_m1) begin
                    n_fill    = wr_next;
                    n_removed = r_fill - wr_next;
                    n_strobe  = 1'b1;
                    n_status  = ST_PURGE_DONE;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_wr    = wr_next;
                    n_state = S_PRG_RD;
                end
            end
            S_DMP_RD: begin
                n_state = S_DMP_EMIT;
            end
            S_DMP_EMIT: begin
                n_strobe = 1'b1;
                n_status = ST_EMIT;
                n_out    = mem_rdata;
                n_last   = (idx_ext == fill_m1);
                if (idx_ext == fill_m1) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_thr    <= DEF_PURGE_THRESHOLD;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_thr    <= n_thr;
            o_strobe <= n_strobe;
        end
        r_idx           <= n_idx;
        r_wr            <= n_wr;
        r_new           <= n_new;
        o_status        <= n_status;
        o_out_id        <= n_out.id;
        o_out_name      <= n_out.name;
        o_out_key       <= n_out.key;
        o_entry_count   <= fill_wide[CNT_W-1:0];
        o_removed_count <= removed_wide[CNT_W-1:0];
        o_last          <= n_last;
    end

    // fill level never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill level above table depth");

    // a command ends with its last result in the same cycle
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_last))
        else $error("command ended without a last result");

    // only a dump produces results that are not last
    a_multi_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (o_status == ST_EMIT))
        else $error("non-final result outside a dump");

    // removed entries are only reported by a purge
    a_removed_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_removed_count != '0)) |-> (o_status == ST_PURGE_DONE))
        else $error("removed count outside a purge");

endmodule

// ===== tb/sorted_record_table_unit_test.sv =====
// testbench for sorted_record_table_unit: directed and random commands checked against a table model
`timescale 1ns / 100ps

module sorted_record_table_unit_test;
    import srt_pkg::*;

    localparam int                  DEPTH          = DEF_TABLE_DEPTH;
    localparam logic [KIND_W-1:0]   KIND_UNUSED    = 2'd3;
    localparam logic [ID_W-1:0]     ID_MAX         = 27'd99999999;
    localparam int                  SETTLE_CYCLES  = 2 * DEPTH + 8;
    localparam int                  TAIL_ITEMS     = 25;
    localparam int                  RAND_PER_PHASE = 19;
    localparam int                  STALL_LIMIT    = 2000;

    // one queued command; a threshold write carries its value in key
    typedef struct packed {
        logic              is_cfg;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [NAME_W-1:0] name;
        logic [KEY_W-1:0]  key;
    } t_cmd;

    // one result as seen on the output ports
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [NAME_W-1:0]   name;
        logic [KEY_W-1:0]    key;
        logic [CNT_W-1:0]    entry_count;
        logic [CNT_W-1:0]    removed_count;
        logic                last;
    } t_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [KIND_W-1:0]     i_kind          = '0;
    logic [ID_W-1:0]       i_record_id     = '0;
    logic [NAME_W-1:0]     i_name_handle   = '0;
    logic [KEY_W-1:0]      i_key_value     = '0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [KEY_W-1:0]      i_cfg_data      = '0;
    logic                  o_strobe;
    logic [STATUS_W-1:0]   o_status;
    logic [ID_W-1:0]       o_out_id;
    logic [NAME_W-1:0]     o_out_name;
    logic [KEY_W-1:0]      o_out_key;
    logic [CNT_W-1:0]      o_entry_count;
    logic [CNT_W-1:0]      o_removed_count;
    logic                  o_last;

    t_cmd      pending_cmds[$];
    t_result   awaited_results[$];

    // table model state
    t_entry            model_rows[DEPTH];
    int                model_fill  = 0;
    logic [KEY_W-1:0]  model_limit = DEF_PURGE_THRESHOLD;

    // driver bookkeeping
    int gap_left     = 0;
    int quiet_cycles = 0;
    int n_accepted   = 0;
    int n_fail       = 0;
    int stall_cycles = 0;

    sorted_record_table_unit #(.TABLE_DEPTH(DEPTH)) dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // model: apply one accepted command and queue the results it causes
    task automatic table_apply(input t_cmd c);
        t_result r;
        int      pos;
        int      kept;
        r = '0;
        r.last = 1'b1;
        case (c.kind)
            KIND_INSERT: begin
                if (model_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_fill && model_rows[pos].key <= c.key)
                        pos++;
                    for (int i = model_fill; i > pos; i--)
                        model_rows[i] = model_rows[i-1];
                    model_rows[pos] = '{id: c.id, name: c.name, key: c.key};
                    model_fill++;
                    r.status = ST_INS_DONE;
                end
                r.entry_count = CNT_W'(model_fill);
                awaited_results.push_back(r);
            end
            KIND_PURGE: begin
                kept = 0;
                for (int i = 0; i < model_fill; i++) begin
                    if (model_rows[i].key <= model_limit) begin
                        model_rows[kept] = model_rows[i];
                        kept++;
                    end
                end
                r.status        = ST_PURGE_DONE;
                r.removed_count = CNT_W'(model_fill - kept);
                model_fill      = kept;
                r.entry_count   = CNT_W'(model_fill);
                awaited_results.push_back(r);
            end
            KIND_DUMP: begin
                if (model_fill == 0) begin
                    r.status = ST_PURGE_DONE;
                    awaited_results.push_back(r);
                end else begin
                    for (int i = 0; i < model_fill; i++) begin
                        r.status      = ST_EMIT;
                        r.id          = model_rows[i].id;
                        r.name        = model_rows[i].name;
                        r.key         = model_rows[i].key;
                        r.entry_count = CNT_W'(model_fill);
                        r.last        = (i == model_fill - 1);
                        awaited_results.push_back(r);
                    end
                end
            end
            default: begin
                // unused kind: ignored by the block
            end
        endcase
    endtask

    function automatic void add_cmd(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                    input logic [NAME_W-1:0] name, input logic [KEY_W-1:0] key);
        t_cmd c;
        c = '{is_cfg: 1'b0, kind: kind, id: id, name: name, key: key};
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom_range(0, ID_MAX));
    endfunction

    function automatic logic [NAME_W-1:0] rand_name();
        return NAME_W'($urandom);
    endfunction

    // keys cluster on the extremes, around the threshold and on a few small values; the rest are random
    function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] lim);
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 7))
            0: k = '0;
            1: k = '1;
            2: k = lim;
            3: k = lim + 1'b1;
            4: k = lim - 1'b1;
            5: k = KEY_W'($urandom_range(0, 3));
            default: k = KEY_W'($urandom);
        endcase
        return k;
    endfunction

    function automatic int field_diff(input string fname, input longint unsigned want,
                                      input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    // stimulus, reset and end of run
    initial begin
        logic [KEY_W-1:0]  limits[6];
        logic [KIND_W-1:0] kind;
        t_cmd              c;
        int                made;
        int                run;

        // directed: empty table, extremes, equal keys, unused kind, full table, purge
        add_cmd(KIND_DUMP, '0, '0, '0);
        add_cmd(KIND_PURGE, '0, '0, '0);
        add_cmd(KIND_INSERT, '0, '0, '0);
        add_cmd(KIND_INSERT, ID_MAX, '1, '1);
        add_cmd(KIND_INSERT, rand_id(), rand_name(), DEF_PURGE_THRESHOLD);
        add_cmd(KIND_INSERT, rand_id(), rand_name(), DEF_PURGE_THRESHOLD + 1'b1);
        add_cmd(KIND_INSERT, rand_id(), rand_name(), DEF_PURGE_THRESHOLD);
        add_cmd(KIND_INSERT, rand_id(), rand_name(), DEF_PURGE_THRESHOLD - 1'b1);
        add_cmd(KIND_UNUSED, rand_id(), rand_name(), KEY_W'($urandom));
        add_cmd(KIND_DUMP, '0, '0, '0);
        repeat (DEPTH - 6) add_cmd(KIND_INSERT, rand_id(), rand_name(),
                                   pick_key(DEF_PURGE_THRESHOLD));
        repeat (2) add_cmd(KIND_INSERT, rand_id(), rand_name(), KEY_W'($urandom));
        add_cmd(KIND_DUMP, '0, '0, '0);
        add_cmd(KIND_PURGE, '0, '0, '0);
        add_cmd(KIND_DUMP, '0, '0, '0);

        // random phases, one threshold each
        limits[0] = '0;
        limits[1] = '1;
        limits[2] = KEY_W'($urandom);
        limits[3] = KEY_W'(1);
        limits[4] = '1 - 1'b1;
        limits[5] = DEF_PURGE_THRESHOLD;
        foreach (limits[p]) begin
            c = '0;
            c.is_cfg = 1'b1;
            c.key    = limits[p];
            pending_cmds.push_back(c);
            made = 0;
            while (made < RAND_PER_PHASE) begin
                if ($urandom_range(0, 4) != 0) begin
                    // a run of inserts, then a dump, sometimes a purge and another dump
                    run = $urandom_range(1, DEPTH + 2);
                    repeat (run) add_cmd(KIND_INSERT, rand_id(), rand_name(),
                                         pick_key(limits[p]));
                    add_cmd(KIND_DUMP, rand_id(), rand_name(), KEY_W'($urandom));
                    made += run + 1;
                    if ($urandom_range(0, 1) == 0) begin
                        add_cmd(KIND_PURGE, rand_id(), rand_name(), KEY_W'($urandom));
                        add_cmd(KIND_DUMP, rand_id(), rand_name(), KEY_W'($urandom));
                        made += 2;
                    end
                end else begin
                    kind = KIND_W'($urandom_range(0, 3));
                    add_cmd(kind, rand_id(), rand_name(), pick_key(limits[p]));
                    if (kind != KIND_UNUSED)
                        made++;
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for everything to drain, then for any late result
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || awaited_results.size() != 0 || start || i_cfg_valid);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // driver: commands and threshold writes from the pending queue
    always @(posedge i_clk) begin
        t_cmd c;
        logic nxt_start;
        logic nxt_cfg;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nxt_start = start;
            nxt_cfg   = i_cfg_valid;

            // idle time seen by the block since its last result
            if (!busy && !o_strobe && !start && !i_cfg_valid && awaited_results.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            // command transfer at this edge
            if (start && !busy) begin
                c = pending_cmds.pop_front();
                table_apply(c);
                nxt_start = 1'b0;
                n_accepted++;
                if (pending_cmds.size() > TAIL_ITEMS && (n_accepted / 20) % 3 != 2
                        && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 12);
            end

            // threshold transfer at this edge
            if (i_cfg_valid && o_cfg_ready) begin
                c = pending_cmds.pop_front();
                model_limit = c.key;
                nxt_cfg = 1'b0;
            end

            // present the next item unless one is still waiting
            if (!nxt_start && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() != 0) begin
                    c = pending_cmds[0];
                    if (c.is_cfg) begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            nxt_cfg = 1'b1;
                            i_cfg_data <= c.key;
                        end
                    end else begin
                        nxt_start = 1'b1;
                        i_kind        <= c.kind;
                        i_record_id   <= c.id;
                        i_name_handle <= c.name;
                        i_key_value   <= c.key;
                    end
                end
            end

            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // monitor: compare each result with the oldest awaited one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: status %0d", o_status);
                n_fail++;
            end else begin
                want = awaited_results.pop_front();
                n_fail += field_diff("status", want.status, o_status);
                n_fail += field_diff("out_id", want.id, o_out_id);
                n_fail += field_diff("out_name", want.name, o_out_name);
                n_fail += field_diff("out_key", want.key, o_out_key);
                n_fail += field_diff("entry_count", want.entry_count, o_entry_count);
                n_fail += field_diff("removed_count", want.removed_count, o_removed_count);
                n_fail += field_diff("last", want.last, o_last);
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

endmodule

// ===== sorted_record_table_unit.f =====
hdl/srt_pkg.sv
hdl/srt_entry_ram.sv
hdl/sorted_record_table_unit.sv
tb/sorted_record_table_unit_test.sv
